// ----- src/lkhc_pkg.sv -----
`default_nettype none
package lkhc_pkg;

   localparam int CAPACITY_DEF    = 128;
   localparam int HANDLE_BITS_DEF = 32;
   localparam int KEY_W           = 64;
   localparam int OUT_HANDLE_W    = 32;

   typedef enum logic [1:0] {
      CMD_PROBE  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_GET    = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LOOK = 1'b1
   } state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic cmp_en;
      logic shift_en;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- src/lkhc_cell.sv -----
`default_nettype none
module lkhc_cell #(
   parameter int HANDLE_BITS = lkhc_pkg::HANDLE_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire lkhc_pkg::cell_ctrl_type   ctrl,
   input  wire [lkhc_pkg::KEY_W-1:0]      look_key,
   input  wire                            prev_valid,
   input  wire [lkhc_pkg::KEY_W-1:0]      prev_key,
   input  wire [HANDLE_BITS-1:0]          prev_handle,
   output logic                           valid,
   output logic [lkhc_pkg::KEY_W-1:0]     key,
   output logic [HANDLE_BITS-1:0]         handle,
   output logic                           match
);

   logic                        valid_ff, valid_in;
   logic [lkhc_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [HANDLE_BITS-1:0]      handle_ff, handle_in;
   logic                        match_ff, match_in;

   always_comb begin
      valid_in  = ctrl.shift_en ? prev_valid  : valid_ff;
      key_in    = ctrl.shift_en ? prev_key    : key_ff;
      handle_in = ctrl.shift_en ? prev_handle : handle_ff;
      // compare against the incoming request key
      match_in  = ctrl.cmp_en ? (valid_ff && (key_ff == look_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign valid  = valid_ff;
   assign key    = key_ff;
   assign handle = handle_ff;
   assign match  = match_ff;

endmodule
`default_nettype wire

// ----- src/lru_keyed_handle_cache.sv -----
`default_nettype none
// Channel   | Direction | Ports
// request   | in        | req_valid, req_ready, req_cmd, req_key, req_handle_in
// response  | out       | rsp_valid, rsp_ready, rsp_hit, rsp_handle_out, rsp_status,
//           |           | rsp_evicted, rsp_evicted_key, rsp_evicted_handle
//
// Each request is handled in order: every cell compares the key as the request is
// taken, then the LOOK state shifts the recency chain and loads the response register.
// Reset (synchronous) clears every cell's valid bit; there is no clearing pass.
// A new request is taken once the chain is idle and the response register is
// empty or being drained in the same cycle; a stalled response holds the chain.
module lru_keyed_handle_cache #(
   parameter int CAPACITY    = lkhc_pkg::CAPACITY_DEF,
   parameter int HANDLE_BITS = lkhc_pkg::HANDLE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire [1:0]                           req_cmd,
   input  wire [lkhc_pkg::KEY_W-1:0]           req_key,
   input  wire [lkhc_pkg::OUT_HANDLE_W-1:0]    req_handle_in,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_hit,
   output logic [lkhc_pkg::OUT_HANDLE_W-1:0]   rsp_handle_out,
   output logic                                rsp_status,
   output logic                                rsp_evicted,
   output logic [lkhc_pkg::KEY_W-1:0]          rsp_evicted_key,
   output logic [lkhc_pkg::OUT_HANDLE_W-1:0]   rsp_evicted_handle
);

   localparam int OW = lkhc_pkg::OUT_HANDLE_W;
   localparam int KW = lkhc_pkg::KEY_W;

   // chain position 0 is most recent, position CAPACITY-1 least recent
   lkhc_pkg::state_type      state_ff, state_in;
   lkhc_pkg::cmd_type        cmd_ff, cmd_in;
   logic [KW-1:0]            key_ff, key_in;
   logic [HANDLE_BITS-1:0]   hin_ff, hin_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     hit_ff, hit_in;
   logic [OW-1:0]            hout_ff, hout_in;
   logic                     status_ff, status_in;
   logic                     ev_ff, ev_in;
   logic [KW-1:0]            evk_ff, evk_in;
   logic [OW-1:0]            evh_ff, evh_in;

   logic                     accept;
   logic                     update;
   logic                     any_match;
   logic [HANDLE_BITS-1:0]   match_handle;
   logic [HANDLE_BITS-1:0]   head_handle;
   logic [HANDLE_BITS+OW-1:0] hin_wide;
   logic [HANDLE_BITS+OW-1:0] mh_wide;
   logic [HANDLE_BITS+OW-1:0] lh_wide;

   logic                     c_valid  [CAPACITY];
   logic [KW-1:0]            c_key    [CAPACITY];
   logic [HANDLE_BITS-1:0]   c_handle [CAPACITY];
   logic [CAPACITY-1:0]      c_match;
   logic [CAPACITY-1:0]      suffix;
   lkhc_pkg::cell_ctrl_type  c_ctrl   [CAPACITY];

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkhc_pkg::ST_IDLE: if (accept) state_in = lkhc_pkg::ST_LOOK;
         lkhc_pkg::ST_LOOK: state_in = lkhc_pkg::ST_IDLE;
         default:           state_in = lkhc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         lkhc_pkg::ST_IDLE: req_ready = !rsp_valid_ff || rsp_ready;
         lkhc_pkg::ST_LOOK: req_ready = 1'b0;
         default:           req_ready = 1'b0;
      endcase
   end

   // latch the request; truncate or extend the handle to the stored width
   assign hin_wide = {{HANDLE_BITS{1'b0}}, req_handle_in};
   always_comb begin
      cmd_in = cmd_ff;
      key_in = key_ff;
      hin_in = hin_ff;
      if (accept) begin
         cmd_in = lkhc_pkg::cmd_type'(req_cmd);
         key_in = req_key;
         hin_in = hin_wide[HANDLE_BITS-1:0];
      end
   end

   // hit detection and handle of the matching cell (one-hot match)
   always_comb begin
      any_match    = |c_match;
      match_handle = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_handle = match_handle | (c_match[i] ? c_handle[i] : '0);
      end
   end

   // cells at or above the hit position move down one place
   always_comb begin
      suffix[CAPACITY-1] = c_match[CAPACITY-1];
      for (int i = CAPACITY-2; i >= 0; i--) begin
         suffix[i] = suffix[i+1] | c_match[i];
      end
   end

   always_comb begin
      update = 1'b0;
      if (state_ff == lkhc_pkg::ST_LOOK) begin
         update = (cmd_ff == lkhc_pkg::CMD_INSERT) ||
                  ((cmd_ff == lkhc_pkg::CMD_GET) && any_match);
      end
      head_handle = (cmd_ff == lkhc_pkg::CMD_INSERT) ? hin_ff : match_handle;
      for (int i = 0; i < CAPACITY; i++) begin
         c_ctrl[i].cmp_en   = accept;
         c_ctrl[i].shift_en = update && (any_match ? suffix[i] : 1'b1);
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == 0) begin : g_head
            lkhc_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
               .clock       (clock),
               .reset       (reset),
               .ctrl        (c_ctrl[g]),
               .look_key    (req_key),
               .prev_valid  (1'b1),
               .prev_key    (key_ff),
               .prev_handle (head_handle),
               .valid       (c_valid[g]),
               .key         (c_key[g]),
               .handle      (c_handle[g]),
               .match       (c_match[g])
            );
         end else begin : g_body
            lkhc_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
               .clock       (clock),
               .reset       (reset),
               .ctrl        (c_ctrl[g]),
               .look_key    (req_key),
               .prev_valid  (c_valid[g-1]),
               .prev_key    (c_key[g-1]),
               .prev_handle (c_handle[g-1]),
               .valid       (c_valid[g]),
               .key         (c_key[g]),
               .handle      (c_handle[g]),
               .match       (c_match[g])
            );
         end
      end
   endgenerate

   // response register: load at the end of the shift cycle, drop on take
   assign mh_wide = {{OW{1'b0}}, match_handle};
   assign lh_wide = {{OW{1'b0}}, c_handle[CAPACITY-1]};
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_in       = hit_ff;
      hout_in      = hout_ff;
      status_in    = status_ff;
      ev_in        = ev_ff;
      evk_in       = evk_ff;
      evh_in       = evh_ff;
      if (state_ff == lkhc_pkg::ST_LOOK) begin
         rsp_valid_in = 1'b1;
         hit_in       = any_match;
         hout_in      = ((cmd_ff == lkhc_pkg::CMD_GET) && any_match) ? mh_wide[OW-1:0] : '0;
         status_in    = (cmd_ff == lkhc_pkg::CMD_GET) && !any_match;
         // a miss insert into a full chain pushes the tail cell out
         ev_in        = (cmd_ff == lkhc_pkg::CMD_INSERT) && !any_match &&
                        c_valid[CAPACITY-1];
         evk_in       = ev_in ? c_key[CAPACITY-1] : '0;
         evh_in       = ev_in ? lh_wide[OW-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkhc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      hin_ff    <= hin_in;
      hit_ff    <= hit_in;
      hout_ff   <= hout_in;
      status_ff <= status_in;
      ev_ff     <= ev_in;
      evk_ff    <= evk_in;
      evh_ff    <= evh_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_handle_out     = hout_ff;
   assign rsp_status         = status_ff;
   assign rsp_evicted        = ev_ff;
   assign rsp_evicted_key    = evk_ff;
   assign rsp_evicted_handle = evh_ff;

endmodule
`default_nettype wire

// ----- src/lkhc_checker.sv -----
`default_nettype none
module lkhc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        rsp_hit,
   input wire        rsp_status,
   input wire        rsp_evicted,
   input wire [31:0] rsp_handle_out
);

   // a taken request gives a response once the LOOK state has loaded the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status || rsp_evicted || (rsp_handle_out != 32'd0))) |->
      (rsp_hit != (rsp_status || rsp_evicted)))
      else $error("hit flag disagrees with status or eviction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)))
      else $error("stalled response changed");

endmodule

bind lru_keyed_handle_cache lkhc_checker u_lkhc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_status     (rsp_status),
   .rsp_evicted    (rsp_evicted),
   .rsp_handle_out (rsp_handle_out)
);
`default_nettype wire
